>>> design/sfc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset values for the serial frame checker.
package sfc_pkg;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_HEADER_FIRST  = 8'h12;
    localparam logic [7:0] RST_HEADER_SECOND = 8'h34;
    localparam logic [7:0] RST_TAIL_FIRST    = 8'h1F;
    localparam logic [7:0] RST_TAIL_SECOND   = 8'h2F;
    localparam logic [7:0] RST_MAX_FRAME     = 8'h64;

    // Bytes of framing around the payload: header, length, checksum and tail.
    localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
    // Position of the first byte after the length byte.
    localparam logic [7:0] FIRST_PAYLOAD_POS = 8'd3;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_HEADER_FIRST  = 3'd0;
    localparam t_cfg_index CFG_HEADER_SECOND = 3'd1;
    localparam t_cfg_index CFG_TAIL_FIRST    = 3'd2;
    localparam t_cfg_index CFG_TAIL_SECOND   = 3'd3;
    localparam t_cfg_index CFG_MAX_FRAME     = 3'd4;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CHECKSUM  = 3'd1,
        ST_TAIL      = 3'd2,
        ST_SLIP      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // Parser phase: filling the header window, testing it, or inside a frame.
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_WINDOW = 2'd2,
        PH_FRAME  = 2'd3
    } t_phase;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
        logic [7:0] max_frame_length;
    } t_cfg;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [7:0]  command;
        logic [7:0]  payload_length;
        logic [31:0] success_count;
        logic [7:0]  error_count;
    } t_result;

endpackage

>>> design/sfc_parser.sv
`timescale 1ns / 1ps
// Frame parser: header window, position tracking, checksum and frame counters.
module sfc_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_byte,
    input  sfc_pkg::t_cfg  i_cfg,
    output logic           o_has_result,
    output sfc_pkg::t_result o_result
);
    import sfc_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held_first, n_held_first;
    logic [7:0]  r_held_second, n_held_second;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_first_payload, n_first_payload;
    logic [7:0]  r_check, n_check;
    logic [7:0]  r_tail_first, n_tail_first;
    logic [31:0] r_ok, n_ok;
    logic [7:0]  r_bad, n_bad;

    logic [8:0]  pos_plus3;
    logic [8:0]  pos_plus2;
    logic [8:0]  total_ext;
    logic [8:0]  new_total;

    // Position comparisons are done one bit wider so that nothing wraps.
    assign pos_plus3 = {1'b0, r_pos} + 9'd3;
    assign pos_plus2 = {1'b0, r_pos} + 9'd2;
    assign total_ext = {1'b0, r_total};
    assign new_total = {1'b0, i_byte} + FRAME_OVERHEAD;

    // State register; the parser advances only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_FIRST;
            r_held_first    <= '0;
            r_held_second   <= '0;
            r_pos           <= '0;
            r_total         <= '0;
            r_sum           <= '0;
            r_first_payload <= '0;
            r_check         <= '0;
            r_tail_first    <= '0;
            r_ok            <= '0;
            r_bad           <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_held_first    <= n_held_first;
            r_held_second   <= n_held_second;
            r_pos           <= n_pos;
            r_total         <= n_total;
            r_sum           <= n_sum;
            r_first_payload <= n_first_payload;
            r_check         <= n_check;
            r_tail_first    <= n_tail_first;
            r_ok            <= n_ok;
            r_bad           <= n_bad;
        end
    end

    // Next state and result for the byte at the input.
    always_comb begin
        logic restart;
        restart         = 1'b0;
        n_phase         = r_phase;
        n_held_first    = r_held_first;
        n_held_second   = r_held_second;
        n_pos           = r_pos;
        n_total         = r_total;
        n_sum           = r_sum;
        n_first_payload = r_first_payload;
        n_check         = r_check;
        n_tail_first    = r_tail_first;
        n_ok            = r_ok;
        n_bad           = r_bad;
        o_has_result    = 1'b0;
        o_result.status         = ST_OK;
        o_result.command        = '0;
        o_result.payload_length = '0;

        case (r_phase)
            PH_FIRST: begin
                n_held_first = i_byte;
                n_phase      = PH_SECOND;
            end
            PH_SECOND: begin
                n_held_second = i_byte;
                n_phase       = PH_WINDOW;
            end
            PH_WINDOW: begin
                if (r_held_first == i_cfg.header_first &&
                    r_held_second == i_cfg.header_second) begin
                    // Header found: this byte is the length.
                    if (new_total > {1'b0, i_cfg.max_frame_length}) begin
                        o_has_result            = 1'b1;
                        o_result.status         = ST_TOO_LONG;
                        o_result.payload_length = i_byte;
                        restart                 = 1'b1;
                    end else begin
                        n_total = new_total[7:0];
                        n_sum   = i_byte;
                        n_pos   = FIRST_PAYLOAD_POS;
                        n_phase = PH_FRAME;
                    end
                end else begin
                    // Header slip: slide the window by one byte.
                    n_held_first    = r_held_second;
                    n_held_second   = i_byte;
                    o_has_result    = 1'b1;
                    o_result.status = ST_SLIP;
                end
            end
            PH_FRAME: begin
                if (r_pos == FIRST_PAYLOAD_POS) begin
                    n_first_payload = i_byte;
                end
                n_pos = r_pos + 8'd1;
                if (pos_plus3 < total_ext) begin
                    n_sum = r_sum + i_byte;
                end else if (pos_plus3 == total_ext) begin
                    n_check = i_byte;
                end else if (pos_plus2 == total_ext) begin
                    n_tail_first = i_byte;
                end else begin
                    // Last byte of the frame: judge tail first, then checksum.
                    o_has_result            = 1'b1;
                    o_result.payload_length = r_total - FRAME_OVERHEAD[7:0];
                    restart                 = 1'b1;
                    if (r_tail_first != i_cfg.tail_first ||
                        i_byte != i_cfg.tail_second) begin
                        n_bad           = r_bad + 8'd1;
                        o_result.status = ST_TAIL;
                    end else if (r_sum != r_check) begin
                        n_bad           = r_bad + 8'd1;
                        o_result.status = ST_CHECKSUM;
                    end else begin
                        n_ok             = r_ok + 32'd1;
                        o_result.status  = ST_OK;
                        o_result.command = r_first_payload;
                    end
                end
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase

        // Any finished or dropped frame starts the hunt again with an empty window.
        if (restart) begin
            n_phase         = PH_FIRST;
            n_held_first    = '0;
            n_held_second   = '0;
            n_pos           = '0;
            n_total         = '0;
            n_sum           = '0;
            n_first_payload = '0;
            n_check         = '0;
            n_tail_first    = '0;
        end

        o_result.success_count = n_ok;
        o_result.error_count   = n_bad;
    end

endmodule

>>> design/serial_frame_checker_unit.sv
`timescale 1ns / 1ps
// Serial frame checker: top level with input register, parser and result queue.
//
// The checker takes one received byte per clock cycle while the result queue
// has room, and gives at most one result per byte. A byte is first captured in
// an input register; when it is consumed, the parser updates the header window,
// position counter and running checksum in one pass and places any result in a
// two-entry result queue (output register plus skid stage). The input stalls
// only when a byte waits in the input register while both result entries are
// full. Configuration registers are written through their own port, which is
// always ready, and should be changed only while no frame is in progress.
module serial_frame_checker_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Received byte channel.
    input  logic                  i_rx_valid,
    output logic                  o_rx_stall,
    input  logic [7:0]            i_rx_byte,
    // Result channel.
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic [2:0]            o_status,
    output logic [7:0]            o_command,
    output logic [7:0]            o_payload_length,
    output logic [31:0]           o_success_count,
    output logic [7:0]            o_error_count,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  sfc_pkg::t_cfg_index   i_cfg_index,
    input  logic [7:0]            i_cfg_data
);
    import sfc_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    logic       r_skid_valid, n_skid_valid;
    t_result    r_out, n_out;
    t_result    r_skid, n_skid;

    logic       in_load;
    logic       consume;
    logic       push;
    logic       pop;
    logic       has_result;
    t_result    result;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first     <= RST_HEADER_FIRST;
            r_cfg.header_second    <= RST_HEADER_SECOND;
            r_cfg.tail_first       <= RST_TAIL_FIRST;
            r_cfg.tail_second      <= RST_TAIL_SECOND;
            r_cfg.max_frame_length <= RST_MAX_FRAME;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:  r_cfg.header_first     <= i_cfg_data;
                CFG_HEADER_SECOND: r_cfg.header_second    <= i_cfg_data;
                CFG_TAIL_FIRST:    r_cfg.tail_first       <= i_cfg_data;
                CFG_TAIL_SECOND:   r_cfg.tail_second      <= i_cfg_data;
                CFG_MAX_FRAME:     r_cfg.max_frame_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register handshake.
    assign consume    = r_in_valid && !r_skid_valid;
    assign o_rx_stall = r_in_valid && r_skid_valid;
    assign in_load    = i_rx_valid && !o_rx_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_load) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Parser.
    sfc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (consume),
        .i_byte       (r_in_byte),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Result queue: output register backed by a skid entry.
    assign push = consume && has_result;
    assign pop  = r_out_valid && !i_res_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (push) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (push) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Result ports.
    assign o_res_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_command        = r_out.command;
    assign o_payload_length = r_out.payload_length;
    assign o_success_count  = r_out.success_count;
    assign o_error_count    = r_out.error_count;

endmodule

>>> design/sfc_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the serial frame checker, bound to its top level.
module sfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_res_valid,
    input logic        i_res_stall,
    input logic [2:0]  o_status,
    input logic [7:0]  o_command,
    input logic [7:0]  o_payload_length,
    input logic [31:0] o_success_count,
    input logic [7:0]  o_error_count
);
    import sfc_pkg::*;

    // No result is offered in the cycle after reset.
    a_no_result_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_res_valid
    ) else $error("result valid right after reset");

    // Only an accepted frame carries a command byte.
    a_command_only_on_ok: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != ST_OK) |-> (o_command == 8'd0)
    ) else $error("command byte on a result that is not ok");

    // A header slip reports no length.
    a_slip_has_no_length: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status == ST_SLIP) |-> (o_payload_length == 8'd0)
    ) else $error("header slip with a nonzero length");

    // A stalled result stays offered and unchanged.
    a_stalled_result_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=>
            (o_res_valid && $stable(o_status) && $stable(o_command) &&
             $stable(o_payload_length) && $stable(o_success_count) &&
             $stable(o_error_count))
    ) else $error("stalled result changed");

endmodule

bind serial_frame_checker_unit sfc_checker u_sfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_res_valid      (o_res_valid),
    .i_res_stall      (i_res_stall),
    .o_status         (o_status),
    .o_command        (o_command),
    .o_payload_length (o_payload_length),
    .o_success_count  (o_success_count),
    .o_error_count    (o_error_count)
);

>>> bench/serial_frame_checker_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serial frame checker: framed byte traffic against a predictor.
module serial_frame_checker_unit_test;
    import sfc_pkg::*;

    localparam int          CLK_HALF      = 4;
    localparam int          RESET_CYCLES  = 9;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [7:0]  POS_FIRST     = 8'd0;
    localparam logic [7:0]  POS_SECOND    = 8'd1;
    localparam logic [7:0]  POS_WINDOW    = 8'd2;

    // Opening traffic under the reset settings: a good frame, an empty payload,
    // a checksum error, a header slip followed by an overlong length, and a
    // frame with both tail and checksum wrong.
    localparam logic [7:0] OPENING_BYTES [29] = '{
        8'h12, 8'h34, 8'h01, 8'hAB, 8'hAC, 8'h1F, 8'h2F,
        8'h12, 8'h34, 8'h00, 8'h00, 8'h1F, 8'h2F,
        8'h12, 8'h34, 8'h00, 8'h01, 8'h1F, 8'h2F,
        8'h00, 8'h12, 8'h34, 8'hFF,
        8'h12, 8'h34, 8'h00, 8'h55, 8'h1F, 8'h00
    };

    // Shapes of generated byte sequences.
    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_TAIL,
        FR_BAD_BOTH,
        FR_TOO_LONG,
        FR_NOISE,
        FR_CUT
    } t_frame_kind;

    // Frame parser model plus the queue of results it has announced.
    class frame_predictor;
        t_cfg        cfg;
        logic [7:0]  held_first;
        logic [7:0]  held_second;
        logic [7:0]  position;
        logic [7:0]  frame_total;
        logic [7:0]  running_sum;
        logic [7:0]  first_payload;
        logic [7:0]  rx_check;
        logic [7:0]  rx_tail_first;
        logic [31:0] frames_ok;
        logic [7:0]  frames_bad;
        t_result     pending[$];
        int          mismatches;
        int          results_seen;
        int          status_seen[5];

        function new();
            cfg.header_first     = RST_HEADER_FIRST;
            cfg.header_second    = RST_HEADER_SECOND;
            cfg.tail_first       = RST_TAIL_FIRST;
            cfg.tail_second      = RST_TAIL_SECOND;
            cfg.max_frame_length = RST_MAX_FRAME;
            frames_ok    = '0;
            frames_bad   = '0;
            mismatches   = 0;
            results_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            held_first    = '0;
            held_second   = '0;
            position      = POS_FIRST;
            frame_total   = '0;
            running_sum   = '0;
            first_payload = '0;
            rx_check      = '0;
            rx_tail_first = '0;
        endfunction

        function void announce(t_status st, logic [7:0] cmd, logic [7:0] len);
            t_result r;
            r.status         = st;
            r.command        = cmd;
            r.payload_length = len;
            r.success_count  = frames_ok;
            r.error_count    = frames_bad;
            pending.push_back(r);
        endfunction

        function void write_reg(t_cfg_index idx, logic [7:0] val);
            case (idx)
                CFG_HEADER_FIRST:  cfg.header_first     = val;
                CFG_HEADER_SECOND: cfg.header_second    = val;
                CFG_TAIL_FIRST:    cfg.tail_first       = val;
                CFG_TAIL_SECOND:   cfg.tail_second      = val;
                CFG_MAX_FRAME:     cfg.max_frame_length = val;
                default: ;
            endcase
        endfunction

        // Advance the parser by one accepted byte.
        function void note_byte(logic [7:0] b);
            int         total;
            int         pos;
            logic [7:0] plen;
            case (position)
                POS_FIRST: begin
                    held_first = b;
                    position   = POS_SECOND;
                end
                POS_SECOND: begin
                    held_second = b;
                    position    = POS_WINDOW;
                end
                POS_WINDOW: begin
                    if (held_first == cfg.header_first && held_second == cfg.header_second) begin
                        // Length is checked without wrap against the limit.
                        total = int'(b) + int'(FRAME_OVERHEAD);
                        if (total > int'(cfg.max_frame_length)) begin
                            restart_hunt();
                            announce(ST_TOO_LONG, 8'd0, b);
                        end else begin
                            frame_total = total[7:0];
                            running_sum = b;
                            position    = FIRST_PAYLOAD_POS;
                        end
                    end else begin
                        held_first  = held_second;
                        held_second = b;
                        announce(ST_SLIP, 8'd0, 8'd0);
                    end
                end
                default: begin
                    pos   = int'(position);
                    total = int'(frame_total);
                    if (position == FIRST_PAYLOAD_POS) first_payload = b;
                    if (pos + 3 < total) begin
                        running_sum = running_sum + b;
                        position    = position + 8'd1;
                    end else if (pos + 3 == total) begin
                        rx_check = b;
                        position = position + 8'd1;
                    end else if (pos + 2 == total) begin
                        rx_tail_first = b;
                        position      = position + 8'd1;
                    end else begin
                        // Last byte: a bad tail wins over a bad checksum.
                        plen = frame_total - FRAME_OVERHEAD[7:0];
                        if (rx_tail_first != cfg.tail_first || b != cfg.tail_second) begin
                            frames_bad = frames_bad + 8'd1;
                            announce(ST_TAIL, 8'd0, plen);
                        end else if (running_sum != rx_check) begin
                            frames_bad = frames_bad + 8'd1;
                            announce(ST_CHECKSUM, 8'd0, plen);
                        end else begin
                            frames_ok = frames_ok + 32'd1;
                            announce(ST_OK, first_payload, plen);
                        end
                        restart_hunt();
                    end
                end
            endcase
        endfunction

        // Compare one transferred result with the oldest announced one.
        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d cmd %02h len %0d ok %0d bad %0d",
                             got.status, got.command, got.payload_length,
                             got.success_count, got.error_count);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status || got.command != want.command ||
                got.payload_length != want.payload_length ||
                got.success_count != want.success_count ||
                got.error_count != want.error_count) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d mismatch: expected st %0d cmd %02h len %0d ok %0d bad %0d",
                             results_seen, want.status, want.command, want.payload_length,
                             want.success_count, want.error_count);
                    $display("    got st %0d cmd %02h len %0d ok %0d bad %0d",
                             got.status, got.command, got.payload_length,
                             got.success_count, got.error_count);
                end
            end else begin
                status_seen[want.status]++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid;
    logic        i_res_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_command;
    logic [7:0]  o_payload_length;
    logic [31:0] o_success_count;
    logic [7:0]  o_error_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic [7:0]  i_cfg_data;

    frame_predictor pred;
    t_result        seen_result;
    int             snd_idle_pct;
    int             rcv_idle_pct;
    bit             hold_results;
    int             cycle_count;
    int             bytes_sent;
    int             rx_stall_cycles;
    int             settings_used;

    serial_frame_checker_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_status         (o_status),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_success_count  (o_success_count),
        .o_error_count    (o_error_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock.
    always #CLK_HALF i_clk = ~i_clk;

    // Receiver back-pressure: random idling, or a long hold-off when requested.
    always @(negedge i_clk) begin
        i_res_stall <= hold_results || ($urandom_range(99) < rcv_idle_pct);
    end

    // Result monitor: every result transfer is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            seen_result.status         = t_status'(o_status);
            seen_result.command        = o_command;
            seen_result.payload_length = o_payload_length;
            seen_result.success_count  = o_success_count;
            seen_result.error_count    = o_error_count;
            pred.check_result(seen_result);
        end
        if (i_rx_valid && o_rx_stall) rx_stall_cycles++;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pred.pending.size());
            $display("status: fail");
            $finish;
        end
    end

    // Offer one byte and wait for its transfer; the predictor sees it on transfer.
    task send_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_rx_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        pred.note_byte(b);
        bytes_sent++;
    endtask

    // Stop sending, then wait for every announced result and for the pipeline to empty.
    task wait_idle();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (pred.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(input t_cfg_index idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pred.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task hold_receiver();
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_results = 1'b0;
    endtask

    // Send one byte sequence of the given shape with the current framing bytes.
    task send_frame(input t_frame_kind kind, input int len);
        int         cut;
        logic [7:0] sum;
        logic [7:0] pay;
        logic [7:0] tail_a;
        logic [7:0] tail_b;
        if (kind == FR_NOISE) begin
            repeat (len) send_byte(8'($urandom_range(255)));
            return;
        end
        send_byte(pred.cfg.header_first);
        send_byte(pred.cfg.header_second);
        send_byte(len[7:0]);
        if (kind == FR_TOO_LONG) return;
        cut = (kind == FR_CUT) ? $urandom_range(0, len) : len;
        sum = len[7:0];
        repeat (cut) begin
            pay = 8'($urandom_range(255));
            sum = sum + pay;
            send_byte(pay);
        end
        if (kind == FR_CUT) return;
        tail_a = pred.cfg.tail_first;
        tail_b = pred.cfg.tail_second;
        if (kind == FR_BAD_TAIL || kind == FR_BAD_BOTH) begin
            if ($urandom_range(1)) tail_a = tail_a ^ 8'($urandom_range(1, 255));
            else                   tail_b = tail_b ^ 8'($urandom_range(1, 255));
        end
        if (kind == FR_BAD_SUM || kind == FR_BAD_BOTH) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
        send_byte(tail_a);
        send_byte(tail_b);
    endtask

    // Mostly well-formed frames with short payloads, plus faults and line noise.
    task send_random_frame();
        int         r;
        int         maxl;
        int         len;
        int         lo;
        logic [7:0] mx;
        mx   = pred.cfg.max_frame_length;
        maxl = (mx >= FRAME_OVERHEAD) ? int'(mx) - int'(FRAME_OVERHEAD) : 8;
        len  = $urandom_range(0, (maxl < 8) ? maxl : 8);
        if ($urandom_range(99) < 3) len = $urandom_range(0, maxl);
        r = $urandom_range(99);
        if (r < 60) begin
            send_frame(FR_GOOD, len);
        end else if (r < 68) begin
            send_frame(FR_BAD_SUM, len);
        end else if (r < 76) begin
            send_frame(FR_BAD_TAIL, len);
        end else if (r < 80) begin
            send_frame(FR_BAD_BOTH, len);
        end else if (r < 86) begin
            lo = (mx >= FRAME_OVERHEAD) ? maxl + 1 : 0;
            send_frame(FR_TOO_LONG, $urandom_range(lo, 255));
        end else if (r < 93) begin
            send_frame(FR_NOISE, $urandom_range(1, 5));
        end else begin
            send_frame(FR_CUT, len);
        end
    endtask

    // One setting of the registers followed by random traffic.
    task run_phase(input logic [7:0] hf, input logic [7:0] hs, input logic [7:0] tf,
                   input logic [7:0] ts, input logic [7:0] mx, input int snd, input int rcv,
                   input int n_bytes, input bit with_hold, input int long_len);
        int target;
        wait_idle();
        write_reg(CFG_HEADER_FIRST, hf);
        write_reg(CFG_HEADER_SECOND, hs);
        write_reg(CFG_TAIL_FIRST, tf);
        write_reg(CFG_TAIL_SECOND, ts);
        write_reg(CFG_MAX_FRAME, mx);
        settings_used++;
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        if (with_hold) begin
            fork
                hold_receiver();
            join_none
        end
        if (long_len >= 0) send_frame(FR_GOOD, long_len);
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) send_random_frame();
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_rx_valid      = 1'b0;
        i_rx_byte       = '0;
        i_res_stall     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_HEADER_FIRST;
        i_cfg_data      = '0;
        hold_results    = 1'b0;
        snd_idle_pct    = 18;
        rcv_idle_pct    = 73;
        cycle_count     = 0;
        bytes_sent      = 0;
        rx_stall_cycles = 0;
        settings_used   = 1;
        pred            = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed traffic under the reset settings.
        foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

        // Random settings with the widest limit, including one full-size frame.
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'hFF, 18, 73, 100, 1'b0, 249);
        // Extreme framing bytes; only empty payloads fit, then nothing fits.
        run_phase(8'h00, 8'h00, 8'hFF, 8'hFF, 8'd6, 73, 18, 60, 1'b0, -1);
        run_phase(8'hFF, 8'hFF, 8'h00, 8'h00, 8'd0, 73, 18, 30, 1'b0, -1);
        // Reset values written back, no idling, long receiver hold-off.
        run_phase(RST_HEADER_FIRST, RST_HEADER_SECOND, RST_TAIL_FIRST, RST_TAIL_SECOND,
                  RST_MAX_FRAME, 0, 0, 80, 1'b1, -1);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(6, 255)), 0, 0, 50, 1'b0, -1);
        wait_idle();

        $display("sent %0d bytes under %0d register settings; input held back for %0d cycles",
                 bytes_sent, settings_used, rx_stall_cycles);
        $display("results: %0d ok, %0d checksum, %0d tail, %0d slip, %0d too long",
                 pred.status_seen[ST_OK], pred.status_seen[ST_CHECKSUM],
                 pred.status_seen[ST_TAIL], pred.status_seen[ST_SLIP],
                 pred.status_seen[ST_TOO_LONG]);
        $display("mismatched results: %0d", pred.mismatches);
        if (pred.mismatches == 0 && pred.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
